// ----- design/spid_pkg.sv -----
// Shared types and constants of the speed PID controller.
`default_nettype none

package spid_pkg;

  typedef logic signed [15:0] speed_cm_t;
  typedef logic signed [18:0] target_t;
  typedef logic        [19:0] tick_time_t;
  typedef logic signed [15:0] throttle_t;
  typedef logic signed [31:0] gain_t;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_KP = 2'd0;
  localparam logic [1:0] REG_KI = 2'd1;
  localparam logic [1:0] REG_KD = 2'd2;

  localparam logic signed [23:0] PREV_ERR_RESET = 24'sd7680;
  localparam logic        [19:0] KPH_DIVISOR    = 20'd125;
  localparam logic        [25:0] KPH_ROUND      = 26'd62;

  localparam throttle_t THROTTLE_MAX = 16'sd16384;
  localparam throttle_t THROTTLE_MIN = -16'sd16384;

endpackage

`default_nettype wire

// ----- design/spid_if.sv -----
// Handshake channels for speed samples and drive commands.
`default_nettype none

interface spid_tick_if;
  logic                valid;
  logic                ready;
  spid_pkg::speed_cm_t measured_speed;
  spid_pkg::target_t   target_speed;
  spid_pkg::tick_time_t tick_time;

  modport source (output valid, output measured_speed, output target_speed,
                  output tick_time, input ready);
  modport sink (input valid, input measured_speed, input target_speed,
                input tick_time, output ready);
endinterface

interface spid_drive_if;
  logic                valid;
  logic                ready;
  spid_pkg::throttle_t throttle;
  logic                clamped;

  modport source (output valid, output throttle, output clamped, input ready);
  modport sink (input valid, input throttle, input clamped, output ready);
endinterface

`default_nettype wire

// ----- design/speed_pid_controller_core.sv -----
// Cruise-control PID core with serial divider, digit-serial multiplier and output clamp.
//
//   channel  | direction | carries
//   ---------+-----------+----------------------------------------------
//   tick     | in        | measured_speed, target_speed, tick_time
//   drive    | out       | throttle, clamped
//   APB      | in        | gain_proportional, gain_integral, gain_derivative
//
// When tick_time is zero the derivative division is skipped.
// The one-bit-per-cycle divider takes 26 steps for km/h and 37 for the derivative,
// and the 32x8 multiplier takes six steps for each of the four products.
// A new transaction is accepted as soon as the previous result sits in the output register.
// Synchronous reset clears the gains and the integral and sets the previous error to 30 km/h.
`default_nettype none

module speed_pid_controller_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  spid_tick_if.sink                      tick,
  spid_drive_if.source                   drive,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [spid_pkg::ADDR_W-1:0] paddr,
  input  wire logic [spid_pkg::DATA_W-1:0] pwdata,
  output logic      [spid_pkg::DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KPH   = 4'd1;
  localparam logic [3:0] S_ERR   = 4'd2;
  localparam logic [3:0] S_EDT   = 4'd3;
  localparam logic [3:0] S_INTEG = 4'd4;
  localparam logic [3:0] S_DDIV  = 4'd5;
  localparam logic [3:0] S_TLOAD = 4'd6;
  localparam logic [3:0] S_TMUL  = 4'd7;
  localparam logic [3:0] S_TACC  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [1:0] T_PROP  = 2'd0;
  localparam logic [1:0] T_INTEG = 2'd1;
  localparam logic [1:0] T_DERIV = 2'd2;

  localparam logic signed [47:0] INTEG_MAX  = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] INTEG_MIN  = {1'b1, {47{1'b0}}};
  localparam logic        [56:0] TERM_LIMIT = {1'b1, 56'd0};
  localparam logic signed [59:0] ONE_Q24    = 60'sd16777216;
  localparam logic signed [59:0] M_ONE_Q24  = -60'sd16777216;

  logic [3:0]  state;
  logic [5:0]  cnt;
  logic [1:0]  tsel;

  spid_pkg::gain_t gain_proportional;
  spid_pkg::gain_t gain_integral;
  spid_pkg::gain_t gain_derivative;

  logic                     s_neg;
  spid_pkg::target_t        target_r;
  spid_pkg::tick_time_t     dt_r;
  logic signed [20:0]       err;
  logic signed [23:0]       prev_err;
  logic signed [47:0]       integ;
  logic                     dneg;

  logic [37:0] dq;
  logic [19:0] rem;
  logic [19:0] dvs;

  logic [31:0] mc;
  logic [47:0] mp;
  logic [79:0] prod;
  logic        mneg;
  logic signed [59:0] sum;

  logic                  result_valid;
  spid_pkg::throttle_t   result_throttle;
  logic                  result_clamped;

  logic        cfg_write;
  logic [15:0] speed_mag;
  logic [25:0] kph_dividend;
  logic [20:0] div_shift;
  logic        div_ge;
  logic [20:0] div_sub;
  logic [19:0] rem_next;
  logic [37:0] dq_next;
  logic [39:0] mul_top;
  logic [79:0] prod_next;
  logic signed [20:0] kph_s;
  logic signed [20:0] err_w;
  logic [20:0] err_w_mag;
  logic [20:0] err_mag;
  logic signed [48:0] ed_term;
  logic signed [48:0] integ_sum;
  logic signed [47:0] integ_next;
  logic signed [23:0] diff;
  logic [20:0] diff_mag;
  logic [31:0] kp_mag;
  logic [31:0] ki_mag;
  logic [31:0] kd_mag;
  logic [47:0] integ_mag;
  logic [79:0] term_q;
  logic        term_sat;
  logic [56:0] term_mag;
  logic signed [59:0] term_ext;
  logic signed [26:0] rnd;
  logic        over;
  logic        under;
  logic        out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      spid_pkg::REG_KP: prdata = gain_proportional;
      spid_pkg::REG_KI: prdata = gain_integral;
      spid_pkg::REG_KD: prdata = gain_derivative;
      default:          prdata = '0;
    endcase
  end

  assign tick.ready     = (state == S_IDLE);
  assign drive.valid    = result_valid;
  assign drive.throttle = result_throttle;
  assign drive.clamped  = result_clamped;
  assign out_free       = !result_valid || drive.ready;

  assign speed_mag    = tick.measured_speed[15] ? 16'(-tick.measured_speed)
                                                : 16'(tick.measured_speed);
  assign kph_dividend = {speed_mag, 10'd0} + {3'd0, speed_mag, 7'd0} + spid_pkg::KPH_ROUND;

  assign div_shift = {rem, dq[37]};
  assign div_ge    = div_shift >= {1'b0, dvs};
  assign div_sub   = div_shift - {1'b0, dvs};
  assign rem_next  = div_ge ? div_sub[19:0] : div_shift[19:0];
  assign dq_next   = {dq[36:0], div_ge};

  assign mul_top   = {8'd0, prod[79:48]} + ({8'd0, mc} * {32'd0, mp[7:0]});
  assign prod_next = {mul_top, prod[47:8]};

  assign kph_s     = s_neg ? -$signed({2'b00, dq[18:0]}) : $signed({2'b00, dq[18:0]});
  assign err_w     = {{2{target_r[18]}}, target_r} - kph_s;
  assign err_w_mag = err_w[20] ? 21'(-err_w) : 21'(err_w);
  assign err_mag   = err[20] ? 21'(-err) : 21'(err);

  assign ed_term    = err[20] ? -$signed({9'd0, prod[39:0]}) : $signed({9'd0, prod[39:0]});
  assign integ_sum  = {integ[47], integ} + ed_term;
  assign integ_next = (integ_sum[48] != integ_sum[47]) ? (integ_sum[48] ? INTEG_MIN : INTEG_MAX)
                                                      : integ_sum[47:0];

  assign diff     = {{3{err[20]}}, err} - prev_err;
  assign diff_mag = diff[23] ? 21'(-diff) : 21'(diff);

  assign kp_mag    = gain_proportional[31] ? 32'(-gain_proportional) : 32'(gain_proportional);
  assign ki_mag    = gain_integral[31] ? 32'(-gain_integral) : 32'(gain_integral);
  assign kd_mag    = gain_derivative[31] ? 32'(-gain_derivative) : 32'(gain_derivative);
  assign integ_mag = integ[47] ? 48'(-integ) : 48'(integ);

  assign term_q   = (tsel == T_INTEG) ? {16'd0, prod[79:16]} : prod;
  assign term_sat = (|term_q[79:57]) || (term_q[56] && (|term_q[55:0]));
  assign term_mag = term_sat ? TERM_LIMIT : term_q[56:0];
  assign term_ext = $signed({3'd0, term_mag});

  assign over  = sum > ONE_Q24;
  assign under = sum < M_ONE_Q24;
  assign rnd   = sum[26:0] + 27'sd512;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= '0;
      gain_integral     <= '0;
      gain_derivative   <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        spid_pkg::REG_KP: gain_proportional <= pwdata;
        spid_pkg::REG_KI: gain_integral     <= pwdata;
        spid_pkg::REG_KD: gain_derivative   <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      tsel         <= T_PROP;
      integ        <= '0;
      prev_err     <= spid_pkg::PREV_ERR_RESET;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && drive.ready && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            s_neg    <= tick.measured_speed[15];
            target_r <= tick.target_speed;
            dt_r     <= tick.tick_time;
            dq       <= {kph_dividend, 12'd0};
            rem      <= '0;
            dvs      <= spid_pkg::KPH_DIVISOR;
            cnt      <= 6'd26;
            state    <= S_KPH;
          end
        end
        S_KPH: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err   <= err_w;
          mc    <= {12'd0, dt_r};
          mp    <= {27'd0, err_w_mag};
          prod  <= '0;
          cnt   <= 6'd6;
          state <= S_EDT;
        end
        S_EDT: begin
          prod <= prod_next;
          mp   <= {8'd0, mp[47:8]};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          integ    <= integ_next;
          prev_err <= {{3{err[20]}}, err};
          sum      <= '0;
          tsel     <= T_PROP;
          if (dt_r == '0) begin
            dneg  <= 1'b0;
            dq    <= '0;
            state <= S_TLOAD;
          end else begin
            dneg  <= diff[23];
            dq    <= {diff_mag, 17'd0};
            rem   <= '0;
            dvs   <= dt_r;
            cnt   <= 6'd37;
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_TLOAD;
          end
        end
        S_TLOAD: begin
          case (tsel)
            T_PROP: begin
              mc   <= kp_mag;
              mp   <= {27'd0, err_mag};
              mneg <= gain_proportional[31] ^ err[20];
            end
            T_INTEG: begin
              mc   <= ki_mag;
              mp   <= integ_mag;
              mneg <= gain_integral[31] ^ integ[47];
            end
            default: begin
              mc   <= kd_mag;
              mp   <= {11'd0, dq[36:0]};
              mneg <= gain_derivative[31] ^ dneg;
            end
          endcase
          prod  <= '0;
          cnt   <= 6'd6;
          state <= S_TMUL;
        end
        S_TMUL: begin
          prod <= prod_next;
          mp   <= {8'd0, mp[47:8]};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_TACC;
          end
        end
        S_TACC: begin
          sum <= mneg ? sum - term_ext : sum + term_ext;
          if (tsel == T_DERIV) begin
            state <= S_OUT;
          end else begin
            tsel  <= tsel + 2'd1;
            state <= S_TLOAD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (over) begin
              result_throttle <= spid_pkg::THROTTLE_MAX;
              result_clamped  <= 1'b1;
            end else if (under) begin
              result_throttle <= spid_pkg::THROTTLE_MIN;
              result_clamped  <= 1'b1;
            end else begin
              result_throttle <= rnd[25:10];
              result_clamped  <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> !tick.ready)
    else $error("A second transaction was accepted while the core was busy.");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_KPH || state == S_DDIV) |-> rem < dvs)
    else $error("The divider remainder is not below the divisor.");

  a_throttle_range: assert property (@(posedge clk) disable iff (rst)
    drive.valid |-> (drive.throttle >= spid_pkg::THROTTLE_MIN &&
                     drive.throttle <= spid_pkg::THROTTLE_MAX))
    else $error("The throttle lies outside the clamp range.");

  a_clamp_rail: assert property (@(posedge clk) disable iff (rst)
    drive.valid && drive.clamped |-> (drive.throttle == spid_pkg::THROTTLE_MAX ||
                                      drive.throttle == spid_pkg::THROTTLE_MIN))
    else $error("A clamped result is not at a rail.");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_speed_pid_controller_core.sv -----
// Self-checking testbench for the speed PID controller core with its own throttle predictor.
`default_nettype none

module tb_speed_pid_controller_core;

  typedef struct packed {
    spid_pkg::throttle_t throttle;
    logic                clamped;
  } drive_t;

  typedef struct packed {
    logic                 set_gains;
    spid_pkg::gain_t      kp;
    spid_pkg::gain_t      ki;
    spid_pkg::gain_t      kd;
    spid_pkg::speed_cm_t  speed;
    spid_pkg::target_t    target;
    spid_pkg::tick_time_t dt;
    logic                 known;
    spid_pkg::throttle_t  throttle;
    logic                 clamped;
  } tick_row_t;

  typedef enum logic [1:0] {MODE_CRUISE, MODE_WILD, MODE_WINDUP} load_mode_t;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam spid_pkg::gain_t GAIN_ZERO = 32'sd0;
  localparam spid_pkg::gain_t GAIN_ONE = 32'sh0001_0000;
  localparam spid_pkg::gain_t GAIN_MAX = 32'sh7fff_ffff;
  localparam spid_pkg::gain_t GAIN_MIN = spid_pkg::gain_t'(32'h8000_0000);
  localparam spid_pkg::speed_cm_t SPEED_MIN = spid_pkg::speed_cm_t'(-32768);
  localparam spid_pkg::speed_cm_t SPEED_MAX = 16'sd32767;
  localparam spid_pkg::target_t TARGET_MIN = spid_pkg::target_t'(-262144);
  localparam spid_pkg::target_t TARGET_MAX = 19'sd262143;
  localparam spid_pkg::tick_time_t TICK_MAX = 20'hfffff;
  localparam spid_pkg::throttle_t THR_MAX = spid_pkg::THROTTLE_MAX;
  localparam spid_pkg::throttle_t THR_MIN = spid_pkg::THROTTLE_MIN;

  localparam longint TERM_CAP = longint'(1) << 56;
  localparam longint FULL_SCALE = longint'(1) << 24;
  localparam longint WINDUP_MAX = (longint'(1) << 47) - 1;
  localparam longint WINDUP_MIN = -(longint'(1) << 47);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int DIRECTED_ROWS = 24;
  localparam int PHASES = 5;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [spid_pkg::ADDR_W-1:0] paddr;
  logic [spid_pkg::DATA_W-1:0] pwdata;
  logic [spid_pkg::DATA_W-1:0] prdata;
  logic pready;

  spid_tick_if tick ();
  spid_drive_if drive ();

  speed_pid_controller_core dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .drive   (drive),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint kp_gain;
  longint ki_gain;
  longint kd_gain;
  longint windup;
  longint last_error;

  drive_t pending_drive [$];
  drive_t oldest_drive;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;

  logic [15:0] ready_pattern = 16'hffff;
  logic [7:0] pattern_age = 8'd0;
  int stall_hold = 0;

  tick_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b1, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, 19'sd0, 20'd1, 1'b1, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, SPEED_MAX, TARGET_MAX, TICK_MAX, 1'b1, 16'sd0,
      1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, SPEED_MIN, TARGET_MIN, 20'd0, 1'b1, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd1, 19'sd1, 20'd65536, 1'b1, 16'sd0, 1'b0},
    '{1'b1, GAIN_MAX, GAIN_ZERO, GAIN_ZERO, 16'sd0, 19'sd256, 20'd65536, 1'b1, THR_MAX,
      1'b1},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, -19'sd256, 20'd65536, 1'b1, THR_MIN,
      1'b1},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, 19'sd0, 20'd65536, 1'b1, 16'sd0, 1'b0},
    '{1'b1, GAIN_MIN, GAIN_ZERO, GAIN_ZERO, SPEED_MAX, 19'sd0, 20'd1, 1'b1, THR_MAX, 1'b1},
    '{1'b1, GAIN_ONE, GAIN_ZERO, GAIN_ZERO, 16'sd0, 19'sd128, 20'd6554, 1'b1, 16'sd8192, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, 19'sd256, 20'd6554, 1'b1, THR_MAX,
      1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, 19'sd257, 20'd6554, 1'b1, THR_MAX,
      1'b1},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, -19'sd256, 20'd6554, 1'b1, THR_MIN,
      1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, -19'sd257, 20'd6554, 1'b1, THR_MIN,
      1'b1},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd125, 19'sd1152, 20'd6554, 1'b1, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, -16'sd125, -19'sd1152, 20'd6554, 1'b1, 16'sd0,
      1'b0},
    '{1'b1, GAIN_ZERO, GAIN_MAX, GAIN_ZERO, 16'sd0, TARGET_MAX, TICK_MAX, 1'b0, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, TARGET_MIN, 20'd0, 1'b0, 16'sd0, 1'b0},
    '{1'b1, GAIN_ZERO, GAIN_ZERO, GAIN_MAX, 16'sd0, TARGET_MAX, 20'd1, 1'b0, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd0, TARGET_MAX, 20'd0, 1'b1, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, SPEED_MIN, TARGET_MAX, TICK_MAX, 1'b0, 16'sd0,
      1'b0},
    '{1'b1, GAIN_MAX, GAIN_MIN, GAIN_MIN, SPEED_MAX, TARGET_MIN, 20'd1, 1'b0, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, SPEED_MIN, TARGET_MAX, TICK_MAX, 1'b0, 16'sd0,
      1'b0},
    '{1'b1, 32'sh0000_4000, 32'sh0000_1000, 32'sh0000_0100, 16'sd2000, 19'sd20000, 20'd3277,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 16'sd2500, 19'sd20000, 20'd3277, 1'b0, 16'sd0,
      1'b0}
  };

  load_mode_t phase_mode [PHASES] = '{MODE_CRUISE, MODE_WILD, MODE_WINDUP, MODE_CRUISE,
                                      MODE_WILD};
  int phase_len [PHASES] = '{80, 80, 280, 80, 100};

  // Product of two signed values shifted right, truncated toward zero, magnitude capped.
  function automatic longint scaled_product(longint a, longint b, int shift);
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [127:0] mag;
    longint term;
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    mag = (128'(mag_a) * 128'(mag_b)) >> shift;
    if (mag > 128'(TERM_CAP)) mag = 128'(TERM_CAP);
    term = longint'(mag[63:0]);
    return ((a < 0) != (b < 0)) ? -term : term;
  endfunction

  function automatic drive_t predict_drive(spid_pkg::speed_cm_t speed,
                                           spid_pkg::target_t target,
                                           spid_pkg::tick_time_t dt);
    longint speed_mag;
    longint kph;
    longint err;
    longint rate;
    longint total;
    drive_t result;
    speed_mag = (speed < 0) ? -longint'(speed) : longint'(speed);
    kph = (speed_mag * 1152 + 62) / 125;
    if (speed < 0) kph = -kph;
    err = longint'(target) - kph;
    windup = windup + err * longint'(dt);
    if (windup > WINDUP_MAX) windup = WINDUP_MAX;
    if (windup < WINDUP_MIN) windup = WINDUP_MIN;
    rate = 0;
    if (dt != 0) rate = ((err - last_error) * 65536) / longint'(dt);
    last_error = err;
    total = scaled_product(kp_gain, err, 0) + scaled_product(ki_gain, windup, 16)
          + scaled_product(kd_gain, rate, 0);
    if (total > FULL_SCALE) begin
      result.throttle = spid_pkg::THROTTLE_MAX;
      result.clamped = 1'b1;
    end else if (total < -FULL_SCALE) begin
      result.throttle = spid_pkg::THROTTLE_MIN;
      result.clamped = 1'b1;
    end else begin
      result.throttle = spid_pkg::throttle_t'((total + 512) >>> 10);
      result.clamped = 1'b0;
    end
    return result;
  endfunction

  function automatic spid_pkg::gain_t pick_gain();
    case ($urandom_range(0, 5))
      0: return GAIN_ZERO;
      1: return GAIN_MAX;
      2: return GAIN_MIN;
      3: return spid_pkg::gain_t'($urandom);
      default: return spid_pkg::gain_t'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  // Leaves psel high so that back-to-back writes need no extra idle cycle.
  task automatic apb_write(logic [1:0] index, spid_pkg::gain_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_gains(spid_pkg::gain_t kp, spid_pkg::gain_t ki, spid_pkg::gain_t kd);
    tick.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    apb_write(spid_pkg::REG_KP, kp);
    apb_write(spid_pkg::REG_KI, ki);
    apb_write(spid_pkg::REG_KD, kd);
    apb_write(REG_SPARE, spid_pkg::gain_t'($urandom));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    kp_gain = longint'(kp);
    ki_gain = longint'(ki);
    kd_gain = longint'(kd);
  endtask

  task automatic send_tick(spid_pkg::speed_cm_t speed, spid_pkg::target_t target,
                           spid_pkg::tick_time_t dt, logic known, drive_t typed);
    int gap;
    drive_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 4);
        8: gap = $urandom_range(5, 40);
        default: gap = $urandom_range(41, 130);
      endcase
      if (gap != 0) begin
        tick.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick.valid <= 1'b1;
    tick.measured_speed <= speed;
    tick.target_speed <= target;
    tick.tick_time <= dt;
    do @(posedge clk); while (!tick.ready);
    predicted = predict_drive(speed, target, dt);
    pending_drive.push_back(known ? typed : predicted);
  endtask

  always @(posedge clk) begin
    if (!rst && drive.valid && drive.ready) begin
      if (pending_drive.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: throttle %0d clamped %0b", drive.throttle,
                   drive.clamped);
        mismatch_count++;
      end else begin
        oldest_drive = pending_drive.pop_front();
        if (drive.throttle !== oldest_drive.throttle || drive.clamped !== oldest_drive.clamped)
        begin
          if (mismatch_count < 10)
            $display("mismatch: throttle %0d clamped %0b, expected throttle %0d clamped %0b",
                     drive.throttle, drive.clamped, oldest_drive.throttle,
                     oldest_drive.clamped);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
      drive.ready <= 1'b0;
    end else begin
      drive.ready <= ready_pattern[pattern_age[3:0]];
      if (pattern_age == 8'hff) begin
        case ($urandom_range(0, 3))
          0, 1: ready_pattern <= 16'hffff;
          2: ready_pattern <= 16'($urandom) | 16'h0001;
          default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
        endcase
        if ($urandom_range(0, 7) == 0) stall_hold <= $urandom_range(20, 150);
      end
    end
    pattern_age <= pattern_age + 8'd1;
  end

  always @(posedge clk) begin
    if (rst || (tick.valid && tick.ready) || (drive.valid && drive.ready)
        || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAIL speed_pid_controller_core");
    $finish;
  end

  initial begin
    spid_pkg::speed_cm_t speed;
    spid_pkg::target_t target;
    spid_pkg::tick_time_t dt;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick.valid = 1'b0;
    tick.measured_speed = '0;
    tick.target_speed = '0;
    tick.tick_time = '0;
    kp_gain = 0;
    ki_gain = 0;
    kd_gain = 0;
    windup = 0;
    last_error = longint'(spid_pkg::PREV_ERR_RESET);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_gains)
        load_gains(directed_rows[r].kp, directed_rows[r].ki, directed_rows[r].kd);
      send_tick(directed_rows[r].speed, directed_rows[r].target, directed_rows[r].dt,
                directed_rows[r].known,
                drive_t'({directed_rows[r].throttle, directed_rows[r].clamped}));
    end

    // The windup phase holds the error at one extreme long enough to saturate the
    // integral, then swings it to the other extreme.
    for (int p = 0; p < PHASES; p++) begin
      if (phase_mode[p] == MODE_WINDUP)
        load_gains(GAIN_ZERO, pick_gain(), GAIN_ZERO);
      else
        load_gains(pick_gain(), pick_gain(), pick_gain());
      for (int k = 0; k < phase_len[p]; k++) begin
        case (phase_mode[p])
          MODE_CRUISE: begin
            speed = spid_pkg::speed_cm_t'(int'($urandom_range(0, 4500)) - 500);
            target = spid_pkg::target_t'(int'($urandom_range(0, 36000)));
            dt = spid_pkg::tick_time_t'($urandom_range(600, 9000));
          end
          MODE_WILD: begin
            speed = spid_pkg::speed_cm_t'($urandom);
            target = spid_pkg::target_t'($urandom);
            dt = ($urandom_range(0, 15) == 0) ? 20'd0 : spid_pkg::tick_time_t'($urandom);
          end
          default: begin
            if (k < 250) begin
              speed = spid_pkg::speed_cm_t'(-32768 + int'($urandom_range(0, 50)));
              target = spid_pkg::target_t'(262143 - int'($urandom_range(0, 50)));
            end else begin
              speed = spid_pkg::speed_cm_t'(32767 - int'($urandom_range(0, 50)));
              target = spid_pkg::target_t'(-262144 + int'($urandom_range(0, 50)));
            end
            dt = spid_pkg::tick_time_t'(1048575 - $urandom_range(0, 50));
          end
        endcase
        send_tick(speed, target, dt, 1'b0, '0);
      end
    end

    tick.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_drive.size() == 0)
      $display("PASS speed_pid_controller_core");
    else
      $display("FAIL speed_pid_controller_core");
    $finish;
  end

endmodule

`default_nettype wire
